[rtl/core/linear_probe_symbol_table_defines.svh]
// Assertion macros shared by the symbol table RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef LINEAR_PROBE_SYMBOL_TABLE_DEFINES_SVH
`define LINEAR_PROBE_SYMBOL_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPST_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("symbol table check failed");

// Next-cycle implication, disabled while reset is high.
`define LPST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("symbol table check failed");

`endif

[rtl/core/lpst_pkg.sv]
// Types and constants of the linear probing symbol table.
// Used by the hash unit, the slot memory and the top level.
package lpst_pkg;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_INSERTED  = 3'd0;
   localparam logic [2:0] STATUS_FULL      = 3'd1;
   localparam logic [2:0] STATUS_FOUND     = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_BAD_ADDR  = 3'd4;

   // address mod 11 by reciprocal: q = (a * ceil(2^20 / 11)) >> 20, exact for 16-bit a
   localparam int unsigned    HASH_MODULUS = 11;
   localparam int unsigned    HASH_SHIFT   = 20;
   localparam logic [16:0]    HASH_RECIP   = 17'd95326;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_DONE
   } state_type;

   // slot memory port control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_label;
   } ram_ctl_type;

endpackage

[rtl/core/lpst_hash.sv]
// Home slot unit: (address mod 11) mod TABLE_SIZE, with the reciprocal product registered at load.
// Depends on lpst_pkg for the reciprocal constants.
module lpst_hash
   import lpst_pkg::*;
#(
   parameter int TABLE_SIZE = 11,
   parameter int IDX_W      = 4
) (
   input  logic             clock,
   input  logic             load,
   input  logic [15:0]      req_addr,
   input  logic [15:0]      key_addr,
   output logic [IDX_W-1:0] home
);

   logic [32:0]      prod_ff;
   logic [32:0]      prod_in;
   logic [12:0]      quot;
   logic [16:0]      quot_x11;
   logic [16:0]      diff;
   logic [3:0]       fold;
   logic [IDX_W+3:0] fold_ext;

   // form the reciprocal product at accept
   assign prod_in = {17'b0, req_addr} * {16'b0, HASH_RECIP};

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // take the remainder by shift and add, then fold into the table
   always_comb begin
      quot     = prod_ff[HASH_SHIFT +: 13];
      quot_x11 = ({4'b0, quot} << 3) + ({4'b0, quot} << 1) + {4'b0, quot};
      diff     = {1'b0, key_addr} - quot_x11;
      fold     = diff[3:0];
      for (int k = 0; k < 5; k++) begin
         if (int'(fold) >= TABLE_SIZE) begin
            fold = fold - 4'(TABLE_SIZE);
         end
      end
      fold_ext = {{IDX_W{1'b0}}, fold};
   end

   assign home = fold_ext[IDX_W-1:0];

endmodule

[rtl/core/lpst_slot_ram.sv]
// Slot storage: address and label arrays, one read and one write port each.
// Read data is registered; depends on lpst_pkg for the port control struct.
module lpst_slot_ram
   import lpst_pkg::*;
#(
   parameter int DEPTH = 11,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  ram_ctl_type      ctl,
   input  logic [IDX_W-1:0] rd_idx,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [15:0]      wr_addr,
   input  logic [63:0]      wr_label,
   output logic [15:0]      rd_addr_q,
   output logic [63:0]      rd_label_q
);

   logic [15:0] addr_mem [DEPTH];
   logic [63:0] label_mem [DEPTH];

   // write the address on every write, the label only on insert
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         addr_mem[wr_idx] <= wr_addr;
      end
      if (ctl.wr_en && ctl.wr_label) begin
         label_mem[wr_idx] <= wr_label;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_addr_q  <= addr_mem[rd_idx];
         rd_label_q <= label_mem[rd_idx];
      end
   end

endmodule

[rtl/core/linear_probe_symbol_table.sv]
// Linear probing symbol table. Search: probes every slot, from slot 0 upward, after accept.
// Insert: a hash state, then one memory read per probed slot until an empty slot or a full table.
// Zero-address insert: result loads at the accepting edge if the output is free.
// Requests are accepted only when idle, after the last result is registered.
// Reset: a clearing pass over every slot empties the address store, req_stall high.
// Depends on lpst_pkg, lpst_hash, lpst_slot_ram and the assertion macro header.
`include "linear_probe_symbol_table_defines.svh"

module linear_probe_symbol_table
   import lpst_pkg::*;
#(
   parameter int TABLE_SIZE = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_sym_address,
   input  logic [63:0] req_sym_label,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot_index,
   output logic [15:0] rsp_found_address
);

   localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   state_type        state_ff, state_in;
   logic             type_ff;
   logic [15:0]      addr_ff;
   logic [63:0]      label_ff;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] chk_pos_ff, chk_pos_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic             dvalid_ff, dvalid_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_slot_ff, hit_slot_in;
   logic [15:0]      hit_addr_ff, hit_addr_in;
   logic [2:0]       res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;
   logic [15:0]      res_addr_ff, res_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   logic [3:0]       rsp_slot_ff;
   logic [15:0]      rsp_addr_ff;

   logic             load_payload;
   logic             load_hash;
   logic [IDX_W-1:0] home;
   ram_ctl_type      ram_ctl;
   logic [IDX_W-1:0] rd_idx, wr_idx;
   logic [15:0]      wr_addr;
   logic [15:0]      rd_addr_q;
   logic [63:0]      rd_label_q;

   logic             out_free;
   logic             fin;
   logic [2:0]       fin_status;
   logic [IDX_W-1:0] fin_slot;
   logic [15:0]      fin_addr;
   logic             out_load;
   logic [2:0]       out_status;
   logic [IDX_W-1:0] out_slot;
   logic [15:0]      out_addr;
   logic [IDX_W+3:0] out_slot_ext;
   logic             last_chk;
   logic             match;

   lpst_hash #(
      .TABLE_SIZE(TABLE_SIZE),
      .IDX_W     (IDX_W)
   ) u_hash (
      .clock   (clock),
      .load    (load_hash),
      .req_addr(req_sym_address),
      .key_addr(addr_ff),
      .home    (home)
   );

   lpst_slot_ram #(
      .DEPTH(TABLE_SIZE),
      .IDX_W(IDX_W)
   ) u_ram (
      .clock     (clock),
      .ctl       (ram_ctl),
      .rd_idx    (rd_idx),
      .wr_idx    (wr_idx),
      .wr_addr   (wr_addr),
      .wr_label  (label_ff),
      .rd_addr_q (rd_addr_q),
      .rd_label_q(rd_label_q)
   );

   // accept only between items; the output register frees the result side
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_chk  = (cnt_ff == LAST_IDX);
   assign match     = (rd_addr_q != 16'd0) && (rd_label_q == label_ff);

   // next state, memory control and result selection
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      chk_pos_in    = chk_pos_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      dvalid_in     = dvalid_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_addr_in   = hit_addr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_addr_in   = res_addr_ff;
      load_payload  = 1'b0;
      load_hash     = 1'b0;
      ram_ctl       = '0;
      rd_idx        = pos_ff;
      wr_idx        = chk_pos_ff;
      wr_addr       = addr_ff;
      fin           = 1'b0;
      fin_status    = STATUS_NOT_FOUND;
      fin_slot      = '0;
      fin_addr      = 16'd0;
      out_load      = 1'b0;
      out_status    = res_status_ff;
      out_slot      = res_slot_ff;
      out_addr      = res_addr_ff;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the address store to empty
            ram_ctl.wr_en = 1'b1;
            wr_idx        = clr_ff;
            wr_addr       = 16'd0;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               load_payload = 1'b1;
               hit_in       = 1'b0;
               cnt_in       = '0;
               dvalid_in    = 1'b0;
               if (req_type == REQ_SEARCH) begin
                  pos_in   = '0;
                  state_in = ST_PROBE;
               end else if (req_sym_address == 16'd0) begin
                  fin        = 1'b1;
                  fin_status = STATUS_BAD_ADDR;
               end else begin
                  load_hash = 1'b1;
                  state_in  = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            pos_in   = home;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            // issue one read a cycle, check the slot read last cycle
            ram_ctl.rd_en = 1'b1;
            pos_in        = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
            chk_pos_in    = pos_ff;
            dvalid_in     = 1'b1;
            if (dvalid_ff) begin
               cnt_in = cnt_ff + 1'b1;
               if (type_ff == REQ_INSERT) begin
                  if (rd_addr_q == 16'd0) begin
                     ram_ctl.wr_en    = 1'b1;
                     ram_ctl.wr_label = 1'b1;
                     fin              = 1'b1;
                     fin_status       = STATUS_INSERTED;
                     fin_slot         = chk_pos_ff;
                  end else if (last_chk) begin
                     fin        = 1'b1;
                     fin_status = STATUS_FULL;
                  end
               end else begin
                  if (match) begin
                     hit_in      = 1'b1;
                     hit_slot_in = chk_pos_ff;
                     hit_addr_in = rd_addr_q;
                  end
                  if (last_chk) begin
                     fin = 1'b1;
                     if (match) begin
                        fin_status = STATUS_FOUND;
                        fin_slot   = chk_pos_ff;
                        fin_addr   = rd_addr_q;
                     end else if (hit_ff) begin
                        fin_status = STATUS_FOUND;
                        fin_slot   = hit_slot_ff;
                        fin_addr   = hit_addr_ff;
                     end
                  end
               end
            end
         end
         ST_DONE: begin
            // hold the result until the output register frees up
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand a finished result to the output register or park it
      if (fin) begin
         res_status_in = fin_status;
         res_slot_in   = fin_slot;
         res_addr_in   = fin_addr;
         if (out_free) begin
            out_load   = 1'b1;
            out_status = fin_status;
            out_slot   = fin_slot;
            out_addr   = fin_addr;
            state_in   = ST_IDLE;
         end else begin
            state_in = ST_DONE;
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
      out_slot_ext = {4'b0, out_slot};
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (load_payload) begin
         type_ff  <= req_type;
         addr_ff  <= req_sym_address;
         label_ff <= req_sym_label;
      end
      pos_ff        <= pos_in;
      chk_pos_ff    <= chk_pos_in;
      cnt_ff        <= cnt_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_addr_ff   <= hit_addr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_addr_ff   <= res_addr_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_slot_ff   <= out_slot_ext[3:0];
         rsp_addr_ff   <= out_addr;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_found_address = rsp_addr_ff;

   // memory writes come only from the clearing sweep or a probe hit on an empty slot
   `LPST_ASSERT_NOW(a_wr_state, clock, reset, ram_ctl.wr_en,
                    (state_ff == ST_CLEAR) || (state_ff == ST_PROBE))
   `LPST_ASSERT_NOW(a_wr_empty, clock, reset, (state_ff == ST_PROBE) && ram_ctl.wr_en,
                    dvalid_ff && (rd_addr_q == 16'd0) && (type_ff == REQ_INSERT))
   `LPST_ASSERT_NOW(a_no_rsp_in_clear, clock, reset, state_ff == ST_CLEAR,
                    !rsp_valid_ff && req_stall)
   `LPST_ASSERT_NEXT(a_done_waits, clock, reset,
                     (state_ff == ST_DONE) && rsp_valid_ff && rsp_stall,
                     state_ff == ST_DONE)

endmodule

[verif/tb.sv]
// Self-checking testbench for linear_probe_symbol_table: directed and random insert/search beats.
// Depends on lpst_pkg for the request and status codes; holds its own copy of the slot store.
module tb;
   import lpst_pkg::*;

   localparam int TABLE_SIZE     = 11;
   localparam int PHASE_ITEMS    = 300;
   localparam int LONG_HOLD      = 200;
   localparam int HOLD_AFTER     = 40;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot_index;
      logic [15:0] found_address;
   } lookup_result_type;

   // Mirror of the slot store; predicts each result as requests are accepted
   class symtab_scoreboard_type;
      logic [15:0]       slot_addr [TABLE_SIZE];
      logic [63:0]       slot_lbl [TABLE_SIZE];
      lookup_result_type expected_q [$];
      int                mismatches;
      int                results_seen;

      function new();
         foreach (slot_addr[i]) begin
            slot_addr[i] = '0;
            slot_lbl[i]  = '0;
         end
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void note_request(logic kind, logic [15:0] addr, logic [63:0] label);
         lookup_result_type exp;
         int                pos;
         bit                done;
         exp  = '{status: STATUS_NOT_FOUND, slot_index: 4'd0, found_address: 16'd0};
         done = 1'b0;
         if (kind == REQ_INSERT) begin
            if (addr == 16'd0) begin
               exp.status = STATUS_BAD_ADDR;
            end else begin
               // probe upward from the home slot, wrap to slot 0
               pos        = (int'(addr) % HASH_MODULUS) % TABLE_SIZE;
               exp.status = STATUS_FULL;
               for (int n = 0; n < TABLE_SIZE && !done; n++) begin
                  if (slot_addr[pos] == 16'd0) begin
                     slot_addr[pos] = addr;
                     slot_lbl[pos]  = label;
                     exp.status     = STATUS_INSERTED;
                     exp.slot_index = pos[3:0];
                     done           = 1'b1;
                  end else begin
                     pos = (pos + 1 == TABLE_SIZE) ? 0 : pos + 1;
                  end
               end
            end
         end else begin
            // keep the highest-indexed occupied match
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (slot_addr[i] != 16'd0 && slot_lbl[i] == label) begin
                  exp.status        = STATUS_FOUND;
                  exp.slot_index    = i[3:0];
                  exp.found_address = slot_addr[i];
               end
            end
         end
         expected_q.push_back(exp);
      endfunction

      function void check_result(logic [2:0] status, logic [3:0] slot, logic [15:0] addr);
         lookup_result_type exp;
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result beat: status %0d slot %0d addr %h",
                        $time, status, slot, addr);
         end else begin
            exp = expected_q.pop_front();
            if (status !== exp.status || slot !== exp.slot_index
                || addr !== exp.found_address) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: expected status %0d slot %0d addr %h, got %0d %0d %h",
                           $time, exp.status, exp.slot_index, exp.found_address,
                           status, slot, addr);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = REQ_SEARCH;
   logic [15:0] req_sym_address = '0;
   logic [63:0] req_sym_label = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_slot_index;
   logic [15:0] rsp_found_address;

   symtab_scoreboard_type sb = new();
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   logic [63:0]           used_labels [$];

   linear_probe_symbol_table #(.TABLE_SIZE(TABLE_SIZE)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_sym_address   (req_sym_address),
      .req_sym_label     (req_sym_label),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_found_address (rsp_found_address)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one request beat; entered and left right after a rising edge
   task automatic send_beat(logic kind, logic [15:0] addr, logic [63:0] label);
      bit took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_sym_address <= addr;
      req_sym_label   <= label;
      if (kind == REQ_INSERT)
         used_labels.push_back(label);
      // hold the payload until the block takes it
      do begin
         @(negedge clock);
         took = !req_stall;
         if (took)
            sb.note_request(kind, addr, label);
         @(posedge clock);
      end while (!took);
   endtask

   // Receiver: random stalls plus one long hold-off to back up the input
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Sample result beats at the falling edge before the accepting edge
   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_slot_index, rsp_found_address);
      end
   end

   // Abort when neither channel moves a beat for too long
   initial begin
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("linear_probe_symbol_table regression: fail");
      $finish;
   end

   initial begin
      int          idle_by_phase [4];
      int          stall_by_phase [4];
      int          pick;
      logic [15:0] addr;
      logic [63:0] label;
      idle_by_phase  = '{0, 62, 0, 31};
      stall_by_phase = '{0, 0, 62, 31};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-table miss, zero address, collisions, wrap, duplicates, full
      send_beat(REQ_SEARCH, 16'h0000, 64'h0);
      send_beat(REQ_INSERT, 16'h0000, 64'h4142_4344_4546_4748);
      send_beat(REQ_INSERT, 16'd1,     64'h0000_0000_0041_4C46);
      send_beat(REQ_INSERT, 16'd12,    64'h0000_0000_4245_5441);
      send_beat(REQ_INSERT, 16'd23,    64'h0000_0000_0041_4C46);
      send_beat(REQ_SEARCH, 16'h0000, 64'h0000_0000_0041_4C46);
      send_beat(REQ_INSERT, 16'd10,    64'h0000_0000_0043_4841);
      send_beat(REQ_INSERT, 16'd21,    64'h0000_0000_0043_4841);
      send_beat(REQ_SEARCH, 16'h0000, 64'h0000_0000_0043_4841);
      send_beat(REQ_INSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(REQ_INSERT, 16'hFFFF, 64'h0);
      send_beat(REQ_SEARCH, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(REQ_SEARCH, 16'h0000, 64'h0);
      send_beat(REQ_SEARCH, 16'hFFFF, 64'h0000_0000_4245_5441);
      send_beat(REQ_INSERT, 16'd4,     64'h0000_0000_4445_4C54);
      send_beat(REQ_INSERT, 16'd5,     64'h0000_0000_4445_4C54);
      send_beat(REQ_INSERT, 16'd6,     64'h8000_0000_0000_0001);
      send_beat(REQ_INSERT, 16'd7,     64'h7FFF_FFFF_FFFF_FFFE);
      send_beat(REQ_INSERT, 16'd33,    64'h0000_0000_0046_554C);
      send_beat(REQ_INSERT, 16'h0000, 64'h0000_0000_0046_554C);
      send_beat(REQ_SEARCH, 16'h0000, 64'h0000_0000_4E4F_4E45);
      send_beat(REQ_SEARCH, 16'h0000, 64'h0000_0000_4445_4C54);

      // Random: mostly searches for stored labels, plus misses and rejected inserts
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_by_phase[ph];
         recv_stall_pct = stall_by_phase[ph];
         repeat (PHASE_ITEMS) begin
            pick  = $urandom_range(99);
            addr  = 16'($urandom);
            label = {$urandom, $urandom};
            if (pick < 55)
               send_beat(REQ_SEARCH, addr,
                         used_labels[$urandom_range(used_labels.size() - 1)]);
            else if (pick < 75)
               send_beat(REQ_SEARCH, addr, label);
            else if (pick < 95)
               send_beat(REQ_INSERT, addr, label);
            else
               send_beat(REQ_INSERT, 16'h0000, label);
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then let the pipeline settle
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (TABLE_SIZE + 4) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("linear_probe_symbol_table regression: pass");
      else
         $display("linear_probe_symbol_table regression: fail");
      $finish;
   end
endmodule
